/* rtl/core/crsf_pkg.sv */
package crsf_pkg;

  localparam int MAX_FRAME     = 64;
  localparam int CHANNEL_COUNT = 16;
  localparam int STORE_DEPTH   = 22;
  localparam int PAYLOAD_START = 3;
  localparam int CHAN_BITS     = 11;
  localparam int STORE_BITS    = STORE_DEPTH * 8;
  localparam int POS_W         = $clog2(MAX_FRAME + 1);
  localparam int CHIDX_W       = 4;

  localparam logic [7:0] SYNC_RESET = 8'd200;
  localparam logic [7:0] POLY_RESET = 8'd213;
  localparam logic [7:0] RC_RESET   = 8'd22;

  localparam logic [1:0] REG_SYNC_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_CRC_POLY      = 2'd1;
  localparam logic [1:0] REG_RC_FRAME_TYPE = 2'd2;

  typedef struct packed {
    logic take_byte;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic burst_start;
    logic last_chan;
  } stat_t;

  // one byte through the CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/crsf_ctrl.sv */
module crsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_ready,
  input  crsf_pkg::stat_t stat,
  output crsf_pkg::cmd_t  cmd
);
  import crsf_pkg::*;

  typedef enum logic {
    ST_RECV,
    ST_BURST
  } state_t;

  state_t state;

  assign rx_ready      = (state == ST_RECV) && stat.out_free;
  assign cmd.take_byte = rx_valid && rx_ready;
  assign cmd.emit      = (state == ST_BURST) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      case (state)
        ST_RECV: begin
          if (cmd.take_byte && stat.burst_start) state <= ST_BURST;
        end
        ST_BURST: begin
          if (cmd.emit && stat.last_chan) state <= ST_RECV;
        end
        default: state <= ST_RECV;
      endcase
    end
  end

endmodule

/* rtl/core/crsf_dp.sv */
module crsf_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic [7:0]      rx_byte,
  input  crsf_pkg::cmd_t  cmd,
  output crsf_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      frame_type,
  output logic [7:0]      frame_length,
  output logic            crc_ok,
  output logic            channel_valid,
  output logic [3:0]      channel_index,
  output logic [10:0]     channel_value,
  output logic            last
);
  import crsf_pkg::*;

  logic [7:0]            sync_address;
  logic [7:0]            crc_poly;
  logic [7:0]            rc_frame_type;

  logic                  in_frame;
  logic [POS_W-1:0]      byte_position;
  logic [7:0]            declared_length;
  logic [7:0]            type_held;
  logic [7:0]            crc_accum;
  logic [STORE_BITS-1:0] payload_store;
  logic [CHIDX_W-1:0]    emit_index;

  logic [7:0]       len_eff;
  logic [7:0]       type_eff;
  logic [8:0]       end_full;
  logic [8:0]       end_pos;
  logic [8:0]       pos_plus1;
  logic             done;
  logic             len_ok;
  logic             frame_ok;
  logic [POS_W-1:0] store_idx;
  logic             store_en;
  logic             single_load;

  assign len_eff   = (byte_position == POS_W'(1)) ? rx_byte : declared_length;
  assign type_eff  = (byte_position == POS_W'(2)) ? rx_byte : type_held;
  assign end_full  = {1'b0, len_eff} + 9'd2;
  assign end_pos   = (end_full > 9'(MAX_FRAME)) ? 9'(MAX_FRAME) : end_full;
  assign pos_plus1 = 9'(byte_position) + 9'd1;
  assign done      = pos_plus1 >= end_pos;
  assign len_ok    = (len_eff >= 8'd2) && (end_full <= 9'(MAX_FRAME));
  assign frame_ok  = len_ok && (byte_position >= POS_W'(PAYLOAD_START)) &&
                     (rx_byte == crc_accum);
  assign store_idx = byte_position - POS_W'(PAYLOAD_START);
  assign store_en  = !done && (byte_position >= POS_W'(PAYLOAD_START)) &&
                     (store_idx < POS_W'(STORE_DEPTH));

  assign stat.out_free    = !out_valid || out_ready;
  assign stat.burst_start = in_frame && done && frame_ok && (type_eff == rc_frame_type);
  assign stat.last_chan   = emit_index == CHIDX_W'(CHANNEL_COUNT - 1);

  assign single_load = cmd.take_byte && in_frame && done && !stat.burst_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_address  <= SYNC_RESET;
      crc_poly      <= POLY_RESET;
      rc_frame_type <= RC_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SYNC_ADDRESS:  sync_address  <= cfg_data;
        REG_CRC_POLY:      crc_poly      <= cfg_data;
        REG_RC_FRAME_TYPE: rc_frame_type <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame tracking, CRC and payload capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_position   <= '0;
      declared_length <= '0;
      type_held       <= '0;
      crc_accum       <= '0;
      payload_store   <= '0;
      emit_index      <= '0;
    end else if (cmd.take_byte) begin
      if (!in_frame) begin
        if (rx_byte == sync_address) begin
          in_frame        <= 1'b1;
          byte_position   <= POS_W'(1);
          declared_length <= '0;
          type_held       <= '0;
          crc_accum       <= '0;
          payload_store   <= '0;
          emit_index      <= '0;
        end
      end else begin
        if (byte_position == POS_W'(1)) declared_length <= rx_byte;
        if (byte_position == POS_W'(2)) type_held <= rx_byte;
        if (!done && byte_position >= POS_W'(2)) begin
          crc_accum <= crc8_step(crc_accum, rx_byte, crc_poly);
        end
        for (int i = 0; i < STORE_DEPTH; i++) begin
          if (store_en && store_idx == POS_W'(i)) payload_store[i*8 +: 8] <= rx_byte;
        end
        if (done) begin
          in_frame      <= 1'b0;
          byte_position <= '0;
          emit_index    <= '0;
        end else begin
          byte_position <= byte_position + POS_W'(1);
        end
      end
    end else if (cmd.emit) begin
      // channels leave from the low end of the store, 11 bits at a time
      payload_store <= payload_store >> CHAN_BITS;
      emit_index    <= emit_index + CHIDX_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (single_load || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (single_load) begin
      frame_type    <= type_eff;
      frame_length  <= len_eff;
      crc_ok        <= frame_ok;
      channel_valid <= 1'b0;
      channel_index <= '0;
      channel_value <= '0;
      last          <= 1'b1;
    end else if (cmd.emit) begin
      frame_type    <= type_held;
      frame_length  <= declared_length;
      crc_ok        <= 1'b1;
      channel_valid <= 1'b1;
      channel_index <= emit_index;
      channel_value <= payload_store[CHAN_BITS-1:0];
      last          <= stat.last_chan;
    end
  end

endmodule

/* rtl/core/crsf_frame_receiver.sv */
// Frame receiver for the serial RC link.
// Input: one received byte per word on rx_valid/rx_ready/rx_byte. Bytes outside
// a frame are dropped until one equals the sync address register.
// Output: result words on out_valid/out_ready. Every finished frame gives one
// word with its type, length and CRC status and last set; a good frame of the
// RC channel type instead gives CHANNEL_COUNT words, one per 11-bit channel,
// with last on the final one.
// Config: cfg_write/cfg_index/cfg_data, index 0 sync address, 1 CRC polynomial,
// 2 RC frame type; other indexes are ignored. Write only while idle.
// Timing: a frame's single result word is on the output the cycle after its last
// byte is taken; a good RC frame instead starts a channel burst that holds off
// input until the final channel word is sent, one word per cycle through the
// shifting payload store while out_ready stays high, longer while it is low.
// A byte is only taken when the output register is empty or being drained,
// so a stalled output stalls the input. Reset (rst, synchronous) returns the
// registers to their defaults, drops any partial frame and empties the output.
module crsf_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_length,
  output logic        crc_ok,
  output logic        channel_valid,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        last
);
  import crsf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  crsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crsf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_type    (frame_type),
    .frame_length  (frame_length),
    .crc_ok        (crc_ok),
    .channel_valid (channel_valid),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

endmodule

/* tb/crsf_frame_checker.sv */
module crsf_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  frame_type,
  input  logic [7:0]  frame_length,
  input  logic        crc_ok,
  input  logic        channel_valid,
  input  logic [3:0]  channel_index,
  input  logic [10:0] channel_value,
  input  logic        last,
  output int          fail_count,
  output int          words_due,
  output logic        mid_frame
);
  import crsf_pkg::*;

  typedef struct packed {
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic        ok;
    logic        chv;
    logic [3:0]  chi;
    logic [10:0] chval;
    logic        fin;
  } frame_word_t;

  frame_word_t due_words[$];

  logic [7:0] sync_reg, poly_reg, rc_type_reg;
  logic       in_frame;
  int         pos;
  logic [7:0] len_held, type_held, crc_acc;
  logic [STORE_BITS-1:0] payload_bits;

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = acc ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // frame tracker: queues the words the frame is due to give once it ends
  task automatic absorb_byte(input logic [7:0] b);
    int end_pos;
    logic ok;
    frame_word_t w;
    if (!in_frame) begin
      if (b == sync_reg) begin
        in_frame = 1'b1;
        pos = 1;
        len_held = '0;
        type_held = '0;
        crc_acc = '0;
        payload_bits = '0;
      end
      return;
    end
    if (pos == 1) len_held = b;
    end_pos = (int'(len_held) + 2 > MAX_FRAME) ? MAX_FRAME : int'(len_held) + 2;
    if (pos >= 2) begin
      if (pos == 2) type_held = b;
      if (pos + 1 < end_pos) begin
        crc_acc = crc8_next(crc_acc, b, poly_reg);
        if (pos >= PAYLOAD_START && pos - PAYLOAD_START < STORE_DEPTH) begin
          payload_bits[8*(pos-PAYLOAD_START) +: 8] = b;
        end
      end
    end
    pos++;
    if (pos < end_pos) return;
    // last byte of the frame; it must follow at least one type byte
    ok = len_held >= 2 && int'(len_held) + 2 <= MAX_FRAME && pos >= 4 && b == crc_acc;
    in_frame = 1'b0;
    pos = 0;
    w.ftype = type_held;
    w.flen = len_held;
    w.ok = ok;
    if (ok && type_held == rc_type_reg) begin
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        w.chv = 1'b1;
        w.chi = 4'(k);
        w.chval = payload_bits[CHAN_BITS*k +: CHAN_BITS];
        w.fin = (k == CHANNEL_COUNT - 1);
        due_words.push_back(w);
      end
    end else begin
      w.chv = 1'b0;
      w.chi = '0;
      w.chval = '0;
      w.fin = 1'b1;
      due_words.push_back(w);
    end
  endtask

  task automatic check_word();
    frame_word_t w;
    if (due_words.size() == 0) begin
      report($sformatf("unexpected word, type %0h length %0h", frame_type, frame_length));
      return;
    end
    w = due_words.pop_front();
    if (frame_type !== w.ftype)
      report($sformatf("frame_type %0h, want %0h", frame_type, w.ftype));
    if (frame_length !== w.flen)
      report($sformatf("frame_length %0h, want %0h", frame_length, w.flen));
    if (crc_ok !== w.ok)
      report($sformatf("crc_ok %0b, want %0b", crc_ok, w.ok));
    if (channel_valid !== w.chv)
      report($sformatf("channel_valid %0b, want %0b", channel_valid, w.chv));
    if (channel_index !== w.chi)
      report($sformatf("channel_index %0d, want %0d", channel_index, w.chi));
    if (channel_value !== w.chval)
      report($sformatf("channel_value %0d, want %0d", channel_value, w.chval));
    if (last !== w.fin)
      report($sformatf("last %0b, want %0b", last, w.fin));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_reg = SYNC_RESET;
      poly_reg = POLY_RESET;
      rc_type_reg = RC_RESET;
      in_frame = 1'b0;
      pos = 0;
      len_held = '0;
      type_held = '0;
      crc_acc = '0;
      payload_bits = '0;
      due_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SYNC_ADDRESS:  sync_reg = cfg_data;
          REG_CRC_POLY:      poly_reg = cfg_data;
          REG_RC_FRAME_TYPE: rc_type_reg = cfg_data;
          default: ;
        endcase
      end
      // output first: a word never leaves on the edge that takes its byte
      if (out_valid && out_ready) check_word();
      if (rx_valid && rx_ready) absorb_byte(rx_byte);
    end
    words_due <= due_words.size();
    mid_frame <= in_frame;
  end

endmodule

/* tb/crsf_frame_receiver_tb.sv */
module crsf_frame_receiver_tb;
  import crsf_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = CHANNEL_COUNT + 8;
  localparam int PHASE_ITEMS   = 55;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_SYNC} fill_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_SYNC_ADDRESS;
  logic [7:0]  cfg_data = '0;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_type;
  logic [7:0]  frame_length;
  logic        crc_ok;
  logic        channel_valid;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last;

  int   fail_count;
  int   words_due;
  logic mid_frame;

  logic [7:0] cur_sync = SYNC_RESET;
  logic [7:0] cur_poly = POLY_RESET;
  logic [7:0] cur_rc   = RC_RESET;
  int items_sent = 0;
  bit gapless = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  crsf_frame_receiver DUT (.*);

  crsf_frame_checker CHK (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] frame_crc_add(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    c = acc ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ cur_poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // whole frame: sync, length, type, payload, CRC (or a corrupted one)
  task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype, input fill_t fill,
                            input bit corrupt);
    int total;
    logic [7:0] crc, b;
    total = (int'(len) + 2 > MAX_FRAME) ? MAX_FRAME : int'(len) + 2;
    crc = '0;
    gapless = ($urandom_range(0, 3) == 0);
    send_byte(cur_sync, 1'b1);
    for (int p = 1; p < total; p++) begin
      if (p == 1) begin
        b = len;
      end else if (p == total - 1 && p >= 3) begin
        b = corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      end else if (p == 2) begin
        b = ftype;
      end else begin
        case (fill)
          FILL_ONES:  b = 8'hFF;
          FILL_ZEROS: b = 8'h00;
          FILL_SYNC:  b = $urandom_range(0, 1) ? cur_sync : 8'($urandom);
          default:    b = 8'($urandom);
        endcase
      end
      if (p >= 2 && p < total - 1) crc = frame_crc_add(crc, b);
      send_byte(b, 1'b1);
    end
  endtask

  task automatic rand_frame();
    int r, pick;
    logic [7:0] len;
    fill_t fill;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 7);
    fill = (pick < 3) ? fill_t'(pick + 1) : FILL_RANDOM;
    if (r < 45) begin
      len = ($urandom_range(0, 2) == 0) ? 8'd24 : 8'($urandom_range(2, 30));
      send_frame(len, cur_rc, fill, 1'b0);
    end else if (r < 65) begin
      send_frame(8'($urandom_range(2, 20)), 8'($urandom), fill, 1'b0);
    end else if (r < 75) begin
      send_frame(8'($urandom_range(2, 26)), $urandom_range(0, 1) ? cur_rc : 8'($urandom),
                 fill, 1'b1);
    end else if (r < 80) begin
      send_frame(8'($urandom_range(40, MAX_FRAME - 2)), 8'($urandom), fill, 1'b0);
    end else if (r < 86) begin
      case ($urandom_range(0, 2))
        0:       len = 8'd0;
        1:       len = 8'd1;
        default: len = 8'($urandom_range(MAX_FRAME - 1, 255));
      endcase
      send_frame(len, 8'($urandom), fill, 1'b0);
    end else if (r < 94) begin
      // cut-off frame; whatever follows is swallowed as its data
      gapless = 1'b0;
      send_byte(cur_sync, 1'b1);
      send_byte(8'($urandom_range(2, 30)), 1'b1);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b1);
    end else begin
      gapless = 1'b0;
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target || (hold_req && !hold_done)) rand_frame();
  endtask

  // close any open frame, then wait for the block to go quiet
  task automatic settle();
    rx_valid <= 1'b0;
    @(posedge clk);
    gapless = 1'b1;
    while (mid_frame) begin
      send_byte(8'h00, 1'b0);
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] s, input logic [7:0] p, input logic [7:0] r);
    cfg_write <= 1'b1;
    cfg_index <= REG_SYNC_ADDRESS;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_CRC_POLY;
    cfg_data <= p;
    @(posedge clk);
    cfg_index <= REG_RC_FRAME_TYPE;
    cfg_data <= r;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_sync = s;
    cur_poly = p;
    cur_rc = r;
  endtask

  // receiver side: random ready pattern, plus one long hold-off on request
  initial begin
    int run, gap, r;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      run = $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of the registers, directed cases first
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_frame(8'd0, 8'h00, FILL_RANDOM, 1'b0);
    send_frame(8'd1, 8'hAA, FILL_RANDOM, 1'b0);
    send_frame(8'd2, cur_rc, FILL_RANDOM, 1'b0);
    send_frame(8'd6, 8'h55, FILL_SYNC, 1'b0);
    send_frame(8'd4, cur_rc, FILL_ONES, 1'b1);
    run_random(PHASE_ITEMS);
    settle();

    set_regs(8'h00, 8'h00, 8'h00);
    run_random(PHASE_ITEMS);
    settle();

    set_regs(8'hFF, 8'hFF, 8'hFF);
    run_random(PHASE_ITEMS);
    settle();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom));
    run_random(PHASE_ITEMS);
    settle();

    // back to defaults with the output held off long enough to back up the input
    set_regs(SYNC_RESET, POLY_RESET, RC_RESET);
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/crsf_pkg.sv
rtl/core/crsf_ctrl.sv
rtl/core/crsf_dp.sv
rtl/core/crsf_frame_receiver.sv
tb/crsf_frame_checker.sv
tb/crsf_frame_receiver_tb.sv
